>>> rtl/wat_pkg.sv
// ---------------------------------------------------------------------------
// wat_pkg: shared types and constants of the weekday alarm table
// Command codes, status codes, table entry layout and the queued command word.
// ---------------------------------------------------------------------------
package wat_pkg;

	localparam int MAX_ALARMS = 8;
	localparam int SLOT_W     = $clog2(MAX_ALARMS);
	localparam int CNT_W      = $clog2(MAX_ALARMS + 1);

	// Input kinds
	localparam logic [3:0] KIND_ADD      = 4'd0;
	localparam logic [3:0] KIND_SET_TIME = 4'd1;
	localparam logic [3:0] KIND_SET_REP  = 4'd2;
	localparam logic [3:0] KIND_SET_EN   = 4'd3;
	localparam logic [3:0] KIND_SET_ALL  = 4'd4;
	localparam logic [3:0] KIND_CLEAR    = 4'd5;
	localparam logic [3:0] KIND_DELETE   = 4'd6;
	localparam logic [3:0] KIND_READ     = 4'd7;
	localparam logic [3:0] KIND_TICK     = 4'd8;

	// Classified operations
	localparam logic [2:0] OP_NOP    = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_MODIFY = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_DELETE = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;
	localparam logic [2:0] OP_TICK   = 3'd6;

	// Result status
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [2:0] NO_WEEKDAY = 3'd7;

	typedef struct packed {
		logic [3:0] id;
		logic [4:0] hour;
		logic [5:0] minute;
		logic       enable;
		logic [6:0] rep;
	} alarm_t;

	typedef struct packed {
		logic [2:0] op;
		logic       set_time;
		logic       set_rep;
		logic       set_en;
		logic [3:0] tag;
		logic [4:0] hour;
		logic [5:0] minute;
		logic       enable;
		logic [6:0] rep;
		logic [2:0] weekday;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             fired;
		logic [2:0]       fired_slot;
		logic             entry_valid;
		alarm_t           entry;
		logic [3:0]       entry_count;
	} res_t;

endpackage

>>> rtl/wat_in_if.sv
// ---------------------------------------------------------------------------
// wat_in_if: command channel of the weekday alarm table
// Valid/ready handshake carrying one command word.
// ---------------------------------------------------------------------------
interface wat_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] kind;
	logic [3:0] tag;
	logic [4:0] hour;
	logic [5:0] minute;
	logic       enable;
	logic [6:0] repeat_mask;
	logic [2:0] weekday;

	modport source (
		output valid, kind, tag, hour, minute, enable, repeat_mask, weekday,
		input  ready
	);
	modport sink (
		input  valid, kind, tag, hour, minute, enable, repeat_mask, weekday,
		output ready
	);
endinterface

>>> rtl/wat_out_if.sv
// ---------------------------------------------------------------------------
// wat_out_if: result channel of the weekday alarm table
// Valid/ready handshake carrying one result word.
// ---------------------------------------------------------------------------
interface wat_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       fired;
	logic [2:0] fired_slot;
	logic       entry_valid;
	logic [3:0] entry_id;
	logic [4:0] entry_hour;
	logic [5:0] entry_minute;
	logic       entry_enable;
	logic [6:0] entry_repeat;
	logic [3:0] entry_count;

	modport source (
		output valid, status, fired, fired_slot, entry_valid, entry_id, entry_hour,
		       entry_minute, entry_enable, entry_repeat, entry_count,
		input  ready
	);
	modport sink (
		input  valid, status, fired, fired_slot, entry_valid, entry_id, entry_hour,
		       entry_minute, entry_enable, entry_repeat, entry_count,
		output ready
	);
endinterface

>>> rtl/weekday_alarm_table.sv
// A word accepted into the command queue is run by the table engine once it is
// at the queue head and the result register is free or being taken; the result
// is registered. Throughput: one word per cycle while results are taken; the
// table engine compares all eight slots in parallel.
// Reset clears the alarm table, the entry count, the armed bit, the command
// queue and the result valid bit; the result word itself is not reset.
// ---------------------------------------------------------------------------
// weekday_alarm_table: alarm table with weekday repeat masks
// Intake and classification, a two-word command queue and the table engine.
// ---------------------------------------------------------------------------
module weekday_alarm_table
	import wat_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	wat_in_if.sink     in_ch,
	wat_out_if.source  out_ch
);

	logic    armed_q;
	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (cfg_we) begin
			armed_q <= cfg_wdata;
		end
	end

	wat_front u_front (
		.in_ch  (in_ch),
		.q_stat (q_stat),
		.push   (push),
		.cmd    (push_cmd)
	);

	wat_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	wat_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.armed  (armed_q),
		.q_stat (q_stat),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("command queue overrun");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("command queue underrun");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.entry_count <= 4'(MAX_ALARMS)))
		else $error("entry count beyond table size");

	a_fire_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (!out_ch.fired || $past(armed_q)))
		else $error("alarm fired while not armed");

endmodule

>>> rtl/wat_front.sv
// ---------------------------------------------------------------------------
// wat_front: command intake
// Accepts command words and classifies each kind into an operation word.
// ---------------------------------------------------------------------------
module wat_front
	import wat_pkg::*;
(
	wat_in_if.sink  in_ch,
	input  q_stat_t q_stat,
	output logic    push,
	output cmd_t    cmd
);

	assign in_ch.ready = !q_stat.full;
	assign push        = in_ch.valid && !q_stat.full;

	always_comb begin
		cmd          = '0;
		cmd.tag      = in_ch.tag;
		cmd.hour     = in_ch.hour;
		cmd.minute   = in_ch.minute;
		cmd.enable   = in_ch.enable;
		cmd.rep      = in_ch.repeat_mask;
		cmd.weekday  = in_ch.weekday;
		unique case (in_ch.kind)
			KIND_ADD: begin
				cmd.op = OP_ADD;
			end
			KIND_SET_TIME: begin
				cmd.op       = OP_MODIFY;
				cmd.set_time = 1'b1;
			end
			KIND_SET_REP: begin
				cmd.op      = OP_MODIFY;
				cmd.set_rep = 1'b1;
			end
			KIND_SET_EN: begin
				cmd.op     = OP_MODIFY;
				cmd.set_en = 1'b1;
			end
			KIND_SET_ALL: begin
				cmd.op       = OP_MODIFY;
				cmd.set_time = 1'b1;
				cmd.set_rep  = 1'b1;
				cmd.set_en   = 1'b1;
			end
			KIND_CLEAR: begin
				cmd.op = OP_CLEAR;
			end
			KIND_DELETE: begin
				cmd.op = OP_DELETE;
			end
			KIND_READ: begin
				cmd.op = OP_READ;
			end
			KIND_TICK: begin
				cmd.op = OP_TICK;
			end
			default: begin
				cmd.op = OP_NOP;
			end
		endcase
	end

endmodule

>>> rtl/wat_queue.sv
// ---------------------------------------------------------------------------
// wat_queue: two-word command queue
// Decouples the intake from the table engine so each side stalls on its own.
// ---------------------------------------------------------------------------
module wat_queue
	import wat_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t q_stat
);

	cmd_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign head         = buf_q[rd_ptr_q];
	assign q_stat.full  = (fill_q == 2'd2);
	assign q_stat.empty = (fill_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/wat_back.sv
// ---------------------------------------------------------------------------
// wat_back: alarm table engine
// Holds the alarm slots, executes one queued command per cycle while results
// are taken and keeps the result word in an output register until taken.
// ---------------------------------------------------------------------------
module wat_back
	import wat_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    armed,
	input  q_stat_t q_stat,
	input  cmd_t    head,
	output logic    pop,
	wat_out_if.source out_ch
);

	alarm_t             slot_q [MAX_ALARMS];
	logic [CNT_W-1:0]   count_q;
	logic               out_valid_q;
	res_t               res_q;

	alarm_t             slot_d [MAX_ALARMS];
	logic [CNT_W-1:0]   count_d;
	res_t               res_d;

	logic [MAX_ALARMS-1:0] used;
	logic [MAX_ALARMS-1:0] id_hit;
	logic [MAX_ALARMS-1:0] tick_hit;
	logic                  id_found;
	logic [SLOT_W-1:0]     id_slot;
	logic                  tick_found;
	logic [SLOT_W-1:0]     tick_slot;
	logic [CNT_W-1:0]      last_slot;
	logic [7:0]            rep_ext;

	assign pop = !q_stat.empty && (!out_valid_q || out_ch.ready);

	// Parallel compare of every slot, then a priority pick of the lowest one.
	always_comb begin
		id_found   = 1'b0;
		id_slot    = '0;
		tick_found = 1'b0;
		tick_slot  = '0;
		rep_ext    = '0;
		for (int i = 0; i < MAX_ALARMS; i++) begin
			used[i]   = (CNT_W'(i) < count_q);
			id_hit[i] = used[i] && (slot_q[i].id == head.tag);
			rep_ext   = {1'b0, slot_q[i].rep};
			tick_hit[i] = used[i] && slot_q[i].enable
				&& (slot_q[i].hour == head.hour) && (slot_q[i].minute == head.minute)
				&& ((slot_q[i].rep == 7'd0) || rep_ext[head.weekday]);
		end
		for (int i = MAX_ALARMS - 1; i >= 0; i--) begin
			if (id_hit[i]) begin
				id_found = 1'b1;
				id_slot  = SLOT_W'(i);
			end
			if (tick_hit[i]) begin
				tick_found = 1'b1;
				tick_slot  = SLOT_W'(i);
			end
		end
	end

	assign last_slot = count_q - CNT_W'(1);

	always_comb begin
		slot_d            = slot_q;
		count_d           = count_q;
		res_d             = '0;
		unique case (head.op)
			OP_ADD: begin
				if (count_q >= CNT_W'(MAX_ALARMS)) begin
					res_d.status = ST_FULL;
				end else begin
					slot_d[count_q[SLOT_W-1:0]] = '{id: head.tag, hour: head.hour,
						minute: head.minute, enable: head.enable, rep: head.rep};
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_MODIFY: begin
				if (!id_found) begin
					res_d.status = ST_NOT_FOUND;
				end else begin
					if (head.set_time) begin
						slot_d[id_slot].hour   = head.hour;
						slot_d[id_slot].minute = head.minute;
					end
					if (head.set_rep) begin
						slot_d[id_slot].rep = head.rep;
					end
					if (head.set_en) begin
						slot_d[id_slot].enable = head.enable;
					end
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < MAX_ALARMS; i++) begin
					slot_d[i] = '0;
				end
				count_d = '0;
			end
			OP_DELETE: begin
				if (!id_found) begin
					res_d.status = ST_NOT_FOUND;
				end else begin
					// Contents move down one slot while each slot keeps its own id.
					for (int i = 0; i < MAX_ALARMS - 1; i++) begin
						if (SLOT_W'(i) >= id_slot && CNT_W'(i) < last_slot) begin
							slot_d[i]    = slot_q[i + 1];
							slot_d[i].id = slot_q[i].id;
						end
					end
					slot_d[last_slot[SLOT_W-1:0]] = '0;
					count_d = last_slot;
				end
			end
			OP_READ: begin
				if (head.tag < count_q) begin
					res_d.entry_valid = 1'b1;
					res_d.entry       = slot_q[head.tag[SLOT_W-1:0]];
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			OP_TICK: begin
				if (armed && tick_found) begin
					res_d.fired      = 1'b1;
					res_d.fired_slot = 3'(tick_slot);
					// A one-shot disarms itself once it has gone off.
					if (slot_q[tick_slot].rep == 7'd0) begin
						slot_d[tick_slot].enable = 1'b0;
					end
				end
			end
			default: begin
				res_d.status = ST_DONE;
			end
		endcase
		res_d.entry_count = 4'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ALARMS; i++) begin
				slot_q[i] <= '0;
			end
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				slot_q      <= slot_d;
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = res_q.status;
	assign out_ch.fired        = res_q.fired;
	assign out_ch.fired_slot   = res_q.fired_slot;
	assign out_ch.entry_valid  = res_q.entry_valid;
	assign out_ch.entry_id     = res_q.entry.id;
	assign out_ch.entry_hour   = res_q.entry.hour;
	assign out_ch.entry_minute = res_q.entry.minute;
	assign out_ch.entry_enable = res_q.entry.enable;
	assign out_ch.entry_repeat = res_q.entry.rep;
	assign out_ch.entry_count  = res_q.entry_count;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for weekday_alarm_table
// Streams alarm commands through the command channel, predicts every reply
// from a private copy of the alarm table and the armed bit, and compares the
// replies field by field. Both channels idle at random; armed is toggled
// between phases while the block is idle.
// ---------------------------------------------------------------------------
module testbench;
	import wat_pkg::*;

	localparam int         CYCLE_LIMIT     = 200000;
	localparam logic [3:0] KIND_UNUSED_TOP = 4'd15;

	typedef struct packed {
		logic [3:0] kind;
		logic [3:0] tag;
		logic [4:0] hour;
		logic [5:0] minute;
		logic       enable;
		logic [6:0] repeat_mask;
		logic [2:0] weekday;
	} alarm_cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	wat_in_if  cmd_ch ();
	wat_out_if reply_ch ();

	weekday_alarm_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (cmd_ch),
		.out_ch    (reply_ch)
	);

	always #5 clk = ~clk;

	// Private copy of the table state.
	alarm_t alarm_mem [MAX_ALARMS] = '{default: '0};
	int     entry_total = 0;
	logic   armed_now = 1'b0;

	alarm_cmd_t cmd_backlog [$];
	res_t       predicted_replies [$];
	int         cmds_queued = 0;
	int         replies_matched = 0;
	int         fail_count = 0;
	int         cycle_count = 0;

	// Hand-off between the sampling edge and the driving edge.
	logic cmd_took = 1'b0;
	logic reply_took = 1'b0;
	int   send_gap = 0;
	int   take_wait = 0;
	logic send_burst = 1'b0;
	logic take_burst = 1'b0;

	// A few shared alarm times per phase so that ticks and adds meet often.
	logic [4:0] pool_hour [4];
	logic [5:0] pool_minute [4];

	alarm_cmd_t next_cmd;
	alarm_cmd_t seen_cmd;
	res_t       want;

	function automatic int find_tag(logic [3:0] id);
		int k;
		for (k = 0; k < entry_total; k++) begin
			if (alarm_mem[k].id == id)
				return k;
		end
		return -1;
	endfunction

	function automatic res_t predict_reply(alarm_cmd_t c);
		res_t       r;
		int         slot;
		int         k;
		logic [3:0] keep_id;
		r = '0;
		slot = -1;
		case (c.kind)
			KIND_ADD: begin
				if (entry_total >= MAX_ALARMS) begin
					r.status = ST_FULL;
				end else begin
					alarm_mem[entry_total] = '{c.tag, c.hour, c.minute, c.enable,
						c.repeat_mask};
					entry_total++;
				end
			end
			KIND_SET_TIME, KIND_SET_REP, KIND_SET_EN, KIND_SET_ALL: begin
				slot = find_tag(c.tag);
				if (slot < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					if (c.kind == KIND_SET_TIME || c.kind == KIND_SET_ALL) begin
						alarm_mem[slot].hour = c.hour;
						alarm_mem[slot].minute = c.minute;
					end
					if (c.kind == KIND_SET_REP || c.kind == KIND_SET_ALL)
						alarm_mem[slot].rep = c.repeat_mask;
					if (c.kind == KIND_SET_EN || c.kind == KIND_SET_ALL)
						alarm_mem[slot].enable = c.enable;
				end
			end
			KIND_CLEAR: begin
				alarm_mem = '{default: '0};
				entry_total = 0;
			end
			KIND_DELETE: begin
				slot = find_tag(c.tag);
				if (slot < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					// Contents move down a slot, but each slot keeps its own id.
					for (k = slot; k + 1 < entry_total; k++) begin
						keep_id = alarm_mem[k].id;
						alarm_mem[k] = alarm_mem[k + 1];
						alarm_mem[k].id = keep_id;
					end
					alarm_mem[k] = '0;
					entry_total--;
				end
			end
			KIND_READ: begin
				if (c.tag < entry_total) begin
					r.entry_valid = 1'b1;
					r.entry = alarm_mem[c.tag];
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			KIND_TICK: begin
				if (armed_now) begin
					// Ineligible matches are skipped; the search continues past them.
					for (k = 0; k < entry_total && !r.fired; k++) begin
						if (alarm_mem[k].hour == c.hour && alarm_mem[k].minute == c.minute &&
								alarm_mem[k].enable) begin
							if (alarm_mem[k].rep == '0) begin
								alarm_mem[k].enable = 1'b0;
								r.fired = 1'b1;
							end else if (c.weekday != NO_WEEKDAY && alarm_mem[k].rep[c.weekday]) begin
								r.fired = 1'b1;
							end
							if (r.fired)
								r.fired_slot = 3'(k);
						end
					end
				end
			end
			default: ;
		endcase
		r.entry_count = 4'(entry_total);
		return r;
	endfunction

	function automatic alarm_cmd_t random_cmd();
		alarm_cmd_t c;
		int         roll;
		int         pick;
		roll = $urandom_range(99);
		pick = $urandom_range(3);
		if (roll < 24)
			c.kind = KIND_ADD;
		else if (roll < 32)
			c.kind = KIND_SET_TIME;
		else if (roll < 38)
			c.kind = KIND_SET_REP;
		else if (roll < 46)
			c.kind = KIND_SET_EN;
		else if (roll < 52)
			c.kind = KIND_SET_ALL;
		else if (roll < 54)
			c.kind = KIND_CLEAR;
		else if (roll < 63)
			c.kind = KIND_DELETE;
		else if (roll < 77)
			c.kind = KIND_READ;
		else if (roll < 98)
			c.kind = KIND_TICK;
		else
			c.kind = 4'($urandom_range(15, 9));
		c.tag = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(5));
		if ($urandom_range(3) == 0) begin
			c.hour = 5'($urandom);
			c.minute = 6'($urandom);
		end else begin
			c.hour = pool_hour[pick];
			c.minute = pool_minute[pick];
		end
		c.enable = ($urandom_range(4) != 0);
		c.repeat_mask = ($urandom_range(2) == 0) ? 7'd0 : 7'($urandom);
		c.weekday = 3'($urandom_range(7));
		return c;
	endfunction

	task automatic check_field(input string field, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, act_val);
			fail_count++;
		end
	endtask

	task automatic queue_cmd(input logic [3:0] kind, input logic [3:0] id,
			input logic [4:0] hour, input logic [5:0] minute, input logic enable,
			input logic [6:0] repeat_mask, input logic [2:0] weekday);
		cmd_backlog.push_back('{kind, id, hour, minute, enable, repeat_mask, weekday});
		cmds_queued++;
	endtask

	task automatic queue_random(input int count);
		int k;
		for (k = 0; k < 4; k++) begin
			pool_hour[k] = 5'($urandom);
			pool_minute[k] = 6'($urandom);
		end
		for (k = 0; k < count; k++) begin
			cmd_backlog.push_back(random_cmd());
			cmds_queued++;
		end
	endtask

	// The armed bit changes only once every reply has come back.
	task automatic write_armed(input logic value);
		wait (replies_matched == cmds_queued);
		repeat (3) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sampling and prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_took = cmd_ch.valid && cmd_ch.ready;
			reply_took = reply_ch.valid && reply_ch.ready;
			if (cfg_we)
				armed_now = cfg_wdata;
			if (cmd_took) begin
				seen_cmd = '{cmd_ch.kind, cmd_ch.tag, cmd_ch.hour, cmd_ch.minute,
					cmd_ch.enable, cmd_ch.repeat_mask, cmd_ch.weekday};
				predicted_replies.push_back(predict_reply(seen_cmd));
			end
			if (reply_took) begin
				if (predicted_replies.size() == 0) begin
					$error("reply word with no command outstanding");
					fail_count++;
				end else begin
					want = predicted_replies.pop_front();
					check_field("status", want.status, reply_ch.status);
					check_field("fired", want.fired, reply_ch.fired);
					check_field("fired_slot", want.fired_slot, reply_ch.fired_slot);
					check_field("entry_valid", want.entry_valid, reply_ch.entry_valid);
					check_field("entry_id", want.entry.id, reply_ch.entry_id);
					check_field("entry_hour", want.entry.hour, reply_ch.entry_hour);
					check_field("entry_minute", want.entry.minute, reply_ch.entry_minute);
					check_field("entry_enable", want.entry.enable, reply_ch.entry_enable);
					check_field("entry_repeat", want.entry.rep, reply_ch.entry_repeat);
					check_field("entry_count", want.entry_count, reply_ch.entry_count);
					replies_matched++;
				end
			end
		end
	end

	// Command driver.
	always @(negedge clk) begin
		if (arst_n && !(cmd_ch.valid && !cmd_took)) begin
			if (cmd_took) begin
				if ($urandom_range(31) == 0)
					send_burst = ~send_burst;
				send_gap = send_burst ? 0 : $urandom_range(10);
			end
			if (send_gap > 0 || cmd_backlog.size() == 0) begin
				if (send_gap > 0)
					send_gap--;
				cmd_ch.valid <= 1'b0;
			end else begin
				next_cmd = cmd_backlog.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.kind <= next_cmd.kind;
				cmd_ch.tag <= next_cmd.tag;
				cmd_ch.hour <= next_cmd.hour;
				cmd_ch.minute <= next_cmd.minute;
				cmd_ch.enable <= next_cmd.enable;
				cmd_ch.repeat_mask <= next_cmd.repeat_mask;
				cmd_ch.weekday <= next_cmd.weekday;
			end
		end
	end

	// Reply acceptor: may stall after each word it takes, except in a burst.
	always @(negedge clk) begin
		if (arst_n) begin
			if (reply_took) begin
				if ($urandom_range(31) == 0)
					take_burst = ~take_burst;
				take_wait = take_burst ? 0 : $urandom_range(10);
			end
			if (take_wait > 0) begin
				take_wait--;
				reply_ch.ready <= 1'b0;
			end else begin
				reply_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("weekday_alarm_table verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		reply_ch.ready = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = KIND_ADD;
		cmd_ch.tag = '0;
		cmd_ch.hour = '0;
		cmd_ch.minute = '0;
		cmd_ch.enable = 1'b0;
		cmd_ch.repeat_mask = '0;
		cmd_ch.weekday = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Disarmed: lookups on an empty table, extremes of the fields, a tick
		// that must not fire, and an unused kind.
		queue_cmd(KIND_READ, 4'd0, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_DELETE, 4'd3, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_SET_TIME, 4'd3, 5'd4, 6'd5, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_ADD, 4'd15, 5'd31, 6'd63, 1'b1, 7'd127, 3'd0);
		queue_cmd(KIND_ADD, 4'd0, 5'd0, 6'd0, 1'b1, 7'd0, 3'd0);
		queue_cmd(KIND_TICK, 4'd0, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_UNUSED_TOP, 4'd15, 5'd31, 6'd63, 1'b1, 7'd127, 3'd7);

		write_armed(1'b1);
		// The one-shot fires once and disarms itself; weekday seven selects
		// no repeat bit; a disabled match does not hide a later one.
		queue_cmd(KIND_TICK, 4'd0, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_TICK, 4'd0, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_TICK, 4'd0, 5'd31, 6'd63, 1'b0, 7'd0, 3'd6);
		queue_cmd(KIND_TICK, 4'd0, 5'd31, 6'd63, 1'b0, 7'd0, NO_WEEKDAY);
		queue_cmd(KIND_ADD, 4'd1, 5'd0, 6'd0, 1'b1, 7'h01, 3'd0);
		queue_cmd(KIND_TICK, 4'd0, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		for (int k = 2; k <= 6; k++)
			queue_cmd(KIND_ADD, 4'(k), 5'(k), 6'(k * 9), k[0], 7'(k * 17), 3'd0);
		queue_cmd(KIND_ADD, 4'd9, 5'd1, 6'd1, 1'b1, 7'd1, 3'd0);
		queue_cmd(KIND_SET_TIME, 4'd2, 5'd12, 6'd30, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_SET_REP, 4'd3, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_SET_EN, 4'd4, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_SET_ALL, 4'd5, 5'd23, 6'd59, 1'b1, 7'h55, 3'd0);
		queue_cmd(KIND_READ, 4'd4, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_DELETE, 4'd0, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_READ, 4'd1, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_READ, 4'd15, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_CLEAR, 4'd0, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);
		queue_cmd(KIND_READ, 4'd0, 5'd0, 6'd0, 1'b0, 7'd0, 3'd0);

		queue_random(320);
		write_armed(1'b0);
		queue_random(180);
		write_armed(1'b1);
		queue_random(300);

		wait (replies_matched == cmds_queued);
		repeat (10) @(posedge clk);
		if (predicted_replies.size() != 0) begin
			$error("%0d predicted replies never arrived", predicted_replies.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("weekday_alarm_table verification clean");
		else
			$display("weekday_alarm_table verification failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/wat_pkg.sv
rtl/wat_in_if.sv
rtl/wat_out_if.sv
rtl/wat_front.sv
rtl/wat_queue.sv
rtl/wat_back.sv
rtl/weekday_alarm_table.sv
verif/testbench.sv
